// ===== rtl/bhs_pkg.sv =====
// -----------------------------------------------------------------------------
// bhs_pkg
// Shared types and constants of the building hit search block: table
// geometry, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// -----------------------------------------------------------------------------
package bhs_pkg;

    // table geometry
    localparam int MAX_BUILDINGS = 1024;
    localparam int ADDR_W        = $clog2(MAX_BUILDINGS);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int DIM_W         = 16;
    localparam int ENTRY_W       = 2 * DIM_W;
    localparam int QX_W          = 32;
    localparam int SUM_W         = CNT_W + DIM_W;
    localparam int CMP_W         = (SUM_W > QX_W) ? SUM_W + 1 : QX_W + 1;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        STAT_FOUND = 2'd0,
        STAT_X_OOB = 2'd1,
        STAT_Y_OOB = 2'd2
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic append;      // write entry at the fill count
        logic clear;       // empty the table
        logic load_query;  // capture the query and read entry zero
        logic step;        // consume one entry of the scan
        logic emit_empty;  // answer a query on an empty table
        logic emit_scan;   // answer from the entry under scan
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_done;
    } t_dp_stat;

endpackage

// ===== rtl/bhs_ram.sv =====
// -----------------------------------------------------------------------------
// bhs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// -----------------------------------------------------------------------------
module bhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/bhs_ctrl.sv =====
// -----------------------------------------------------------------------------
// bhs_ctrl
// Controller of the building hit search: takes transactions while idle,
// decodes the operation and steps the datapath through a query scan.
// -----------------------------------------------------------------------------
module bhs_ctrl
    import bhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_opcode,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_opcode'(i_opcode) == OP_QUERY) && !i_stat.empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_APPEND: o_cmd.append = !i_stat.full;
                        OP_CLEAR:  o_cmd.clear  = 1'b1;
                        OP_QUERY: begin
                            o_cmd.emit_empty = i_stat.empty;
                            o_cmd.load_query = !i_stat.empty;
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.step      = 1'b1;
                o_cmd.emit_scan = i_stat.scan_done;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/bhs_dp.sv =====
// -----------------------------------------------------------------------------
// bhs_dp
// Datapath of the building hit search: building table, fill count, running
// width sum, scan index and the result register.
// -----------------------------------------------------------------------------
module bhs_dp
    import bhs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DIM_W-1:0]  i_bldg_width,
    input  logic [DIM_W-1:0]  i_bldg_height,
    input  logic [QX_W-1:0]   i_query_x,
    input  logic [DIM_W-1:0]  i_query_y,
    output t_dp_stat          o_stat,
    output logic              o_result_valid,
    output logic [ADDR_W-1:0] o_hit_index,
    output logic [DIM_W-1:0]  o_hit_width,
    output logic [DIM_W-1:0]  o_hit_height,
    output logic [1:0]        o_status
);

    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [QX_W-1:0]    r_qx;
    logic [DIM_W-1:0]   r_qy;
    logic               r_valid;
    logic [ADDR_W-1:0]  r_hit_index;
    logic [DIM_W-1:0]   r_hit_width;
    logic [DIM_W-1:0]   r_hit_height;
    t_status            r_status;

    logic [SUM_W-1:0]   n_sum;
    logic [ENTRY_W-1:0] rd_data;
    logic [DIM_W-1:0]   cur_width;
    logic [DIM_W-1:0]   cur_height;
    logic [ADDR_W-1:0]  rd_addr;
    logic               hit_x;
    logic               last;
    t_status            scan_status;

    // building table, height in the upper half
    bhs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BUILDINGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data ({i_bldg_height, i_bldg_width}),
        .i_rd_en   (i_cmd.load_query || i_cmd.step),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // read entry zero at the start of a query, then run one entry ahead
    assign rd_addr    = i_cmd.load_query ? '0 : r_idx + ADDR_W'(1);
    assign cur_width  = rd_data[DIM_W-1:0];
    assign cur_height = rd_data[ENTRY_W-1:DIM_W];

    // running sum and hit test on the entry under scan
    assign n_sum = r_sum + SUM_W'(cur_width);
    assign hit_x = CMP_W'(n_sum) > CMP_W'(r_qx);
    assign last  = ({1'b0, r_idx} + CNT_W'(1)) == r_count;

    always_comb begin
        priority if (!hit_x) begin
            scan_status = STAT_X_OOB;
        end else if (r_qy > cur_height) begin
            scan_status = STAT_Y_OOB;
        end else begin
            scan_status = STAT_FOUND;
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(MAX_BUILDINGS));
    assign o_stat.scan_done = hit_x || last;

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // query capture and scan progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qx  <= i_query_x;
            r_qy  <= i_query_y;
            r_sum <= '0;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_sum <= n_sum;
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_empty || i_cmd.emit_scan;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_hit_index  <= '0;
            r_hit_width  <= '0;
            r_hit_height <= '0;
            r_status     <= STAT_X_OOB;
        end else if (i_cmd.emit_scan) begin
            r_hit_index  <= r_idx;
            r_hit_width  <= cur_width;
            r_hit_height <= cur_height;
            r_status     <= scan_status;
        end
    end

    assign o_result_valid = r_valid;
    assign o_hit_index    = r_hit_index;
    assign o_hit_width    = r_hit_width;
    assign o_hit_height   = r_hit_height;
    assign o_status       = r_status;

endmodule

// ===== rtl/building_hit_search_top.sv =====
// -----------------------------------------------------------------------------
// building_hit_search_top
// Table of side-by-side buildings with append, clear and point queries.
// -----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   i_opcode selects append (width/height stored at the end of the table),
//   clear (table emptied) or query (point i_query_x, i_query_y).
//   Append and clear finish in the accepting cycle and give no result;
//   an append to a full table is dropped, an unused opcode is ignored.
//   A query scans the table from entry zero, one entry per cycle through
//   the registered read port of the table RAM, until the running width
//   sum exceeds x or the last entry is reached. Busy stays high while
//   entries are examined and o_result_valid pulses in the cycle after
//   the last one; an empty table answers in the cycle after acceptance.
//   The result is shown for one cycle only and the receiver cannot stall
//   it. Reset empties the table and clears busy and the strobe; the table
//   contents themselves are not cleared.
// -----------------------------------------------------------------------------
module building_hit_search_top
    import bhs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_bldg_width,
    input  logic [15:0] i_bldg_height,
    input  logic [31:0] i_query_x,
    input  logic [15:0] i_query_y,
    output logic        o_result_valid,
    output logic [9:0]  o_hit_index,
    output logic [15:0] o_hit_width,
    output logic [15:0] o_hit_height,
    output logic [1:0]  o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller
    bhs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath
    bhs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_bldg_width   (i_bldg_width),
        .i_bldg_height  (i_bldg_height),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_hit_index    (o_hit_index),
        .o_hit_width    (o_hit_width),
        .o_hit_height   (o_hit_height),
        .o_status       (o_status)
    );

endmodule

// ===== rtl/bhs_checker.sv =====
// -----------------------------------------------------------------------------
// bhs_checker
// Port-level checks of the building hit search, bound to the top level.
// -----------------------------------------------------------------------------
module bhs_checker
    import bhs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [1:0]  o_status
);

    // busy only rises after a transaction was taken
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // a result is only given once the scan has ended
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // a result follows a scan cycle or a taken transaction
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) || $past(start)))
        else $error("result strobe without a transaction");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status == STAT_FOUND || o_status == STAT_X_OOB ||
                            o_status == STAT_Y_OOB))
        else $error("undefined result status");

    // no result in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_result_valid)
        else $error("result strobe after reset");

endmodule

bind building_hit_search_top bhs_checker u_bhs_checker (.*);
